// ===== hdl/elevator_car_controller_macros.svh =====
// ----------------------------------------------------------------------------
// elevator_car_controller_macros.svh
// Assertion macros for the elevator car controller.
// ----------------------------------------------------------------------------
`ifndef ELEVATOR_CAR_CONTROLLER_MACROS_SVH
`define ELEVATOR_CAR_CONTROLLER_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ECC_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a consequent follows an antecedent in the same cycle.
`define ECC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ecc_pkg.sv =====
// ----------------------------------------------------------------------------
// ecc_pkg
// Shared types and constants of the elevator car controller.
// ----------------------------------------------------------------------------
package ecc_pkg;

  localparam int FLOOR_W    = 4;
  localparam int TAG_W      = 8;
  localparam int CAP_W      = 5;
  localparam int LOAD_W     = 5;
  localparam int DEST_SLOTS = 1 << FLOOR_W;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [2:0] {
    OP_ADD_STOP = 3'd0,
    OP_BOARD    = 3'd1,
    OP_ALIGHT   = 3'd2,
    OP_MOVE     = 3'd3,
    OP_CLOSE    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_UP   = 2'd1,
    MODE_DOWN = 2'd2,
    MODE_OPEN = 2'd3
  } mode_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [FLOOR_W-1:0] floor_number;
    logic [TAG_W-1:0]   passenger_tag;
  } ecc_in_t;

  typedef struct packed {
    logic [FLOOR_W-1:0] car_floor;
    logic [1:0]         car_mode;
    logic [LOAD_W-1:0]  car_load;
    logic               car_full;
    logic               board_refused;
    logic               alight_valid;
    logic [TAG_W-1:0]   alight_tag;
    logic               last_result;
  } ecc_out_t;

  // One stored rider: destination floor and tag.
  typedef struct packed {
    logic [FLOOR_W-1:0] dest;
    logic [TAG_W-1:0]   tag;
  } rider_t;

  // Command to the motion unit.
  typedef struct packed {
    logic               valid;
    op_t                op;
    logic [FLOOR_W-1:0] floor_number;
  } mot_cmd_t;

  // Motion unit status.
  typedef struct packed {
    logic [FLOOR_W-1:0] floor;
    mode_t              mode;
  } mot_stat_t;

endpackage

// ===== hdl/ecc_rider_mem.sv =====
// ----------------------------------------------------------------------------
// ecc_rider_mem
// Rider store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ecc_rider_mem
  import ecc_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  rider_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output rider_t        rd_data
);

  rider_t mem [0:DEPTH-1];
  rider_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold read data when no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/ecc_motion.sv =====
// ----------------------------------------------------------------------------
// ecc_motion
// Pending stop bitmap, current floor and motion mode; steers toward the
// lowest pending stop.
// ----------------------------------------------------------------------------
module ecc_motion
  import ecc_pkg::*;
#(
  parameter int NUM_FLOORS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  mot_cmd_t  cmd,
  output mot_stat_t stat
);

  localparam int TW = $clog2(NUM_FLOORS);

  logic [NUM_FLOORS-1:0] pend_r, pend_nxt;
  logic [FLOOR_W-1:0]    floor_r, floor_nxt;
  mode_t                 mode_r, mode_nxt;

  logic                  has_stop;
  logic [TW-1:0]         low_idx;
  logic [NUM_FLOORS-1:0] add_mask;
  logic [NUM_FLOORS-1:0] low_mask;
  logic [FLOOR_W-1:0]    step_floor;

  // Lowest set bit of the stop bitmap.
  always_comb begin
    has_stop = 1'b0;
    low_idx  = '0;
    for (int i = NUM_FLOORS - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        has_stop = 1'b1;
        low_idx  = TW'(i);
      end
    end
  end

  // A floor beyond the top gives an empty mask and is ignored.
  always_comb begin
    for (int i = 0; i < NUM_FLOORS; i++) begin
      add_mask[i] = (int'(cmd.floor_number) == i);
      low_mask[i] = (int'(low_idx) == i);
    end
  end

  always_comb begin
    pend_nxt   = pend_r;
    floor_nxt  = floor_r;
    mode_nxt   = mode_r;
    step_floor = floor_r;
    if (cmd.valid) begin
      unique case (cmd.op)
        OP_ADD_STOP: begin
          pend_nxt = pend_r | add_mask;
        end
        OP_MOVE: begin
          if (mode_r != MODE_OPEN) begin
            if (!has_stop) begin
              mode_nxt = MODE_IDLE;
            end else begin
              if (int'(low_idx) > int'(floor_r)) begin
                step_floor = floor_r + 1'b1;
                mode_nxt   = MODE_UP;
              end else if (int'(low_idx) < int'(floor_r)) begin
                step_floor = floor_r - 1'b1;
                mode_nxt   = MODE_DOWN;
              end
              floor_nxt = step_floor;
              // Arrived: drop the stop and open the doors.
              if (int'(low_idx) == int'(step_floor)) begin
                pend_nxt = pend_r & ~low_mask;
                mode_nxt = MODE_OPEN;
              end
            end
          end
        end
        OP_CLOSE: begin
          if (!has_stop) begin
            mode_nxt = MODE_IDLE;
          end else if (int'(low_idx) > int'(floor_r)) begin
            mode_nxt = MODE_UP;
          end else begin
            mode_nxt = MODE_DOWN;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= '0;
      floor_r <= '0;
      mode_r  <= MODE_IDLE;
    end else begin
      pend_r  <= pend_nxt;
      floor_r <= floor_nxt;
      mode_r  <= mode_nxt;
    end
  end

  assign stat.floor = floor_r;
  assign stat.mode  = mode_r;

endmodule

// ===== hdl/elevator_car_controller.sv =====
// ----------------------------------------------------------------------------
// elevator_car_controller
// Add stop, board, move, close, unused codes and an alight with nobody leaving go
// straight to the output register on acceptance; one item a cycle unless stalled.
// Alight with riders leaving: the walk runs in S_SCAN, each result passing the
// rider store read register and then the output register; one stored rider walked a
// cycle (a stalled result holds the walk), and no new item is taken until it ends.
// Reset (synchronous): no stops, ground floor, idle, empty car, capacity 16.
// ----------------------------------------------------------------------------
`include "elevator_car_controller_macros.svh"

module elevator_car_controller
  import ecc_pkg::*;
#(
  parameter int NUM_FLOORS = 16,
  parameter int MAX_RIDERS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  ecc_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output ecc_out_t         out_data
);

  localparam int AW = (MAX_RIDERS > 1) ? $clog2(MAX_RIDERS) : 1;
  localparam int CW = $clog2(MAX_RIDERS + 1);

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  typedef struct packed {
    logic             refused;
    logic             av;
    logic [TAG_W-1:0] tag;
    logic             last;
  } res_t;

  state_t           state_r, state_nxt;
  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    dest_cnt_r [0:DEST_SLOTS-1];
  logic             out_valid_r, out_valid_nxt;
  res_t             res_r, res_nxt;
  logic [CW-1:0]    rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]    wr_idx_r, wr_idx_nxt;
  logic [CW-1:0]    scan_cnt_r, scan_cnt_nxt;
  logic [CW-1:0]    left_r, left_nxt;
  logic             p_vld_r, p_vld_nxt;

  logic             in_acc;
  logic             out_free;
  logic             full;
  logic             dest_inc;
  logic             dest_clr;
  logic [CW-1:0]    n_gone;
  logic             gone;
  logic             consume;
  logic             more;
  logic             issue;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  rider_t           mem_wdata;
  logic             mem_re;
  rider_t           mem_rdata;

  mot_cmd_t         mot_cmd;
  mot_stat_t        mot_stat;

  ecc_motion #(
    .NUM_FLOORS(NUM_FLOORS)
  ) u_motion (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (mot_cmd),
    .stat (mot_stat)
  );

  ecc_rider_mem #(
    .DEPTH(MAX_RIDERS),
    .AW   (AW)
  ) u_rider_mem (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(mem_waddr),
    .wr_data(mem_wdata),
    .rd_en  (mem_re),
    .rd_addr(rd_idx_r[AW-1:0]),
    .rd_data(mem_rdata)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;

  assign full = (32'(count_r) >= 32'(cap_r)) || (32'(count_r) >= MAX_RIDERS);

  assign mot_cmd.valid        = in_acc;
  assign mot_cmd.op           = op_t'(in_data.opcode);
  assign mot_cmd.floor_number = in_data.floor_number;

  assign n_gone  = dest_cnt_r[mot_stat.floor];
  assign gone    = (mem_rdata.dest == mot_stat.floor);
  assign consume = p_vld_r && (!gone || out_free);
  assign more    = (rd_idx_r < scan_cnt_r);
  assign issue   = (state_r == S_SCAN) && (!p_vld_r || consume) && more;

  always_comb begin
    state_nxt     = state_r;
    cap_nxt       = cfg_wr_en ? cfg_wr_data : cap_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    res_nxt       = res_r;
    rd_idx_nxt    = rd_idx_r;
    wr_idx_nxt    = wr_idx_r;
    scan_cnt_nxt  = scan_cnt_r;
    left_nxt      = left_r;
    p_vld_nxt     = p_vld_r;
    dest_inc      = 1'b0;
    dest_clr      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = count_r[AW-1:0];
    mem_wdata     = '{dest: in_data.floor_number, tag: in_data.passenger_tag};
    mem_re        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          out_valid_nxt = 1'b1;
          res_nxt       = '{refused: 1'b0, av: 1'b0, tag: '0, last: 1'b1};
          unique case (op_t'(in_data.opcode))
            OP_BOARD: begin
              if (full) begin
                res_nxt.refused = 1'b1;
              end else begin
                mem_we    = 1'b1;
                count_nxt = count_r + 1'b1;
                dest_inc  = 1'b1;
              end
            end
            OP_ALIGHT: begin
              // With riders leaving, the plain result is replaced by the walk.
              if (n_gone != '0) begin
                out_valid_nxt = out_valid_r && out_stall;
                res_nxt       = res_r;
                count_nxt     = count_r - n_gone;
                dest_clr      = 1'b1;
                scan_cnt_nxt  = count_r;
                left_nxt      = n_gone;
                rd_idx_nxt    = '0;
                wr_idx_nxt    = '0;
                p_vld_nxt     = 1'b0;
                state_nxt     = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        // Reads run ahead of compaction writes, so the addresses never meet.
        if (issue) begin
          mem_re     = 1'b1;
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
        p_vld_nxt = issue || (p_vld_r && !consume);
        if (consume) begin
          if (gone) begin
            out_valid_nxt = 1'b1;
            res_nxt       = '{refused: 1'b0, av: 1'b1, tag: mem_rdata.tag,
                              last: (left_r == CW'(1))};
            left_nxt      = left_r - 1'b1;
          end else begin
            mem_we     = 1'b1;
            mem_waddr  = wr_idx_r[AW-1:0];
            mem_wdata  = mem_rdata;
            wr_idx_nxt = wr_idx_r + 1'b1;
          end
        end
        if (!more && (!p_vld_r || consume)) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      res_r       <= '0;
      p_vld_r     <= 1'b0;
      rd_idx_r    <= '0;
      wr_idx_r    <= '0;
      scan_cnt_r  <= '0;
      left_r      <= '0;
      for (int i = 0; i < DEST_SLOTS; i++) begin
        dest_cnt_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      res_r       <= res_nxt;
      p_vld_r     <= p_vld_nxt;
      rd_idx_r    <= rd_idx_nxt;
      wr_idx_r    <= wr_idx_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      left_r      <= left_nxt;
      if (dest_inc) begin
        dest_cnt_r[in_data.floor_number] <= dest_cnt_r[in_data.floor_number] + 1'b1;
      end else if (dest_clr) begin
        dest_cnt_r[mot_stat.floor] <= '0;
      end
    end
  end

  // Floor, mode and load are live state: nothing changes them while a result waits.
  assign out_valid              = out_valid_r;
  assign out_data.car_floor     = mot_stat.floor;
  assign out_data.car_mode      = mot_stat.mode;
  assign out_data.car_load      = LOAD_W'(count_r);
  assign out_data.car_full      = full;
  assign out_data.board_refused = res_r.refused;
  assign out_data.alight_valid  = res_r.av;
  assign out_data.alight_tag    = res_r.tag;
  assign out_data.last_result   = res_r.last;

  `ECC_ASSERT(a_count_max, 32'(count_r) <= MAX_RIDERS, "rider count above store depth")
  `ECC_ASSERT_IMPL(a_left_bound, state_r == S_SCAN,
    32'(left_r) <= 32'(scan_cnt_r) - 32'(rd_idx_r) + 32'(p_vld_r),
    "more leaving riders expected than entries left to walk")
  `ECC_ASSERT_IMPL(a_walk_done, state_r == S_IDLE && $past(state_r == S_SCAN),
    left_r == '0 && wr_idx_r == count_r, "walk ended with riders unaccounted")

endmodule
